@@ rtl/core/sssf_pkg.sv @@
// ----------------------------------------------------------------------------
// Stereo stem split filter package
// Shared widths, gain constants, operation codes and rounding helpers.
// ----------------------------------------------------------------------------
package sssf_pkg;

  localparam int SAMPLE_BITS   = 24;
  localparam int COEF_BITS     = 26;
  localparam int STATE_BITS    = 32;
  localparam int SAMPLE_FRAC   = SAMPLE_BITS - 1;
  localparam int COEF_FRAC     = COEF_BITS - 3;
  localparam int DEF_STAGES    = 4;
  localparam int MAX_STAGES    = 8;
  localparam int STG_W         = $clog2(MAX_STAGES);
  localparam int MUL_A_BITS    = 36;
  localparam int MUL_B_BITS    = COEF_BITS + 1;
  localparam int PROD_BITS     = MUL_A_BITS + MUL_B_BITS;
  localparam int Q16_FRAC      = 16;

  // signed Q11.16 gains
  localparam logic signed [MUL_B_BITS-1:0] K_SMOOTH     = MUL_B_BITS'(19661);
  localparam logic signed [MUL_B_BITS-1:0] K_ATTACK     = MUL_B_BITS'(6554);
  localparam logic signed [MUL_B_BITS-1:0] K_RELEASE    = MUL_B_BITS'(66);
  localparam logic signed [MUL_B_BITS-1:0] K_LOW_GAIN   = MUL_B_BITS'(78643);
  localparam logic signed [MUL_B_BITS-1:0] K_HIGH_GAIN  = MUL_B_BITS'(52429);
  localparam logic signed [MUL_B_BITS-1:0] K_SIDE_GAIN  = MUL_B_BITS'(19661);
  localparam logic signed [MUL_B_BITS-1:0] K_OTHER_GAIN = MUL_B_BITS'(98304);

  localparam logic [1:0] MODE_BASS   = 2'd0;
  localparam logic [1:0] MODE_VOCALS = 2'd1;
  localparam logic [1:0] MODE_DRUMS  = 2'd2;
  localparam logic [1:0] MODE_OTHER  = 2'd3;

  // configuration register indexes (byte address / 4)
  localparam int         NUM_REGS      = 5;
  localparam logic [2:0] REG_STEM_MODE = 3'd0;
  localparam logic [2:0] REG_LOW_B0    = 3'd1;
  localparam logic [2:0] REG_HIGH_B0   = 3'd2;
  localparam logic [2:0] REG_DEN_A1    = 3'd3;
  localparam logic [2:0] REG_DEN_A2    = 3'd4;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_LOAD,
    OP_CX_START,
    OP_BQ_B0,
    OP_BQ_Y,
    OP_BQ_A1,
    OP_BQ_S1,
    OP_BQ_S2,
    OP_CX_END,
    OP_BASS_OUT,
    OP_VOC_DIFF,
    OP_VOC_MUL,
    OP_VOC_OUT,
    OP_DR_ABS,
    OP_DR_DIFF,
    OP_DR_MUL,
    OP_DR_ENV,
    OP_DR_GAIN,
    OP_DR_MG,
    OP_DR_RG,
    OP_DR_MH,
    OP_DR_ACC0,
    OP_DR_ACC1,
    OP_DR_OUT,
    OP_OT_MUL,
    OP_OT_OUT
  } op_e;

  typedef struct packed {
    op_e              op;
    logic             hi;        // 1: highpass cascade
    logic             src_side;  // cascade input is side instead of mid
    logic [STG_W-1:0] stage;
  } dp_cmd_t;

  // floor((v + 2^(n-1)) / 2^n)
  function automatic logic signed [63:0] rnd(input logic signed [63:0] v,
                                             input int unsigned n);
    logic signed [63:0] half;
    half = 64'sd1 <<< (n - 1);
    return (v + half) >>> n;
  endfunction

  function automatic logic signed [63:0] sat(input logic signed [63:0] v,
                                             input int unsigned bits);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = (64'sd1 <<< (bits - 1)) - 64'sd1;
    lo = -hi - 64'sd1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

endpackage

@@ rtl/core/sssf_ctrl.sv @@
// ----------------------------------------------------------------------------
// Stem split filter controller
// Sequences the biquad stages and the per-mode post steps on the datapath.
// ----------------------------------------------------------------------------
module sssf_ctrl #(
  parameter int BIQUAD_STAGES = sssf_pkg::DEF_STAGES
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [1:0]        stem_mode_i,
  input  logic              in_valid_i,
  input  logic              out_free_i,
  output logic              in_ready_o,
  output sssf_pkg::dp_cmd_t cmd_o
);

  typedef enum logic [4:0] {
    ST_IDLE, ST_CSTART, ST_B0, ST_Y, ST_A1, ST_S1, ST_S2, ST_CEND,
    ST_BASS_OUT, ST_VOC_DIFF, ST_VOC_MUL, ST_VOC_OUT,
    ST_DR_ABS, ST_DR_DIFF, ST_DR_MUL, ST_DR_ENV, ST_DR_GAIN, ST_DR_MG,
    ST_DR_RG, ST_DR_MH, ST_DR_ACC0, ST_DR_ACC1, ST_DR_OUT,
    ST_OT_MUL, ST_OT_OUT
  } state_e;

  localparam logic [sssf_pkg::STG_W-1:0] LastStage = sssf_pkg::STG_W'(BIQUAD_STAGES - 1);

  state_e                     state_q, state_d;
  logic                       hi_q, hi_d;
  logic                       src_q, src_d;
  logic [sssf_pkg::STG_W-1:0] stage_q, stage_d;
  sssf_pkg::op_e              op;

  always_comb begin
    state_d    = state_q;
    hi_d       = hi_q;
    src_d      = src_q;
    stage_d    = stage_q;
    op         = sssf_pkg::OP_NOP;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          op      = sssf_pkg::OP_LOAD;
          state_d = ST_CSTART;
          hi_d    = (stem_mode_i == sssf_pkg::MODE_VOCALS) ||
                    (stem_mode_i == sssf_pkg::MODE_OTHER);
          src_d   = (stem_mode_i == sssf_pkg::MODE_OTHER);
          stage_d = '0;
        end
      end
      ST_CSTART: begin op = sssf_pkg::OP_CX_START; state_d = ST_B0; end
      ST_B0:     begin op = sssf_pkg::OP_BQ_B0;    state_d = ST_Y;  end
      ST_Y:      begin op = sssf_pkg::OP_BQ_Y;     state_d = ST_A1; end
      ST_A1:     begin op = sssf_pkg::OP_BQ_A1;    state_d = ST_S1; end
      ST_S1:     begin op = sssf_pkg::OP_BQ_S1;    state_d = ST_S2; end
      ST_S2: begin
        op = sssf_pkg::OP_BQ_S2;
        if (stage_q == LastStage) begin
          state_d = ST_CEND;
        end else begin
          stage_d = stage_q + 1'b1;
          state_d = ST_B0;
        end
      end
      ST_CEND: begin
        op = sssf_pkg::OP_CX_END;
        if (!hi_q && stem_mode_i == sssf_pkg::MODE_DRUMS) begin
          hi_d    = 1'b1;
          stage_d = '0;
          state_d = ST_CSTART;
        end else begin
          unique case (stem_mode_i)
            sssf_pkg::MODE_BASS:   state_d = ST_BASS_OUT;
            sssf_pkg::MODE_VOCALS: state_d = ST_VOC_DIFF;
            sssf_pkg::MODE_DRUMS:  state_d = ST_DR_ABS;
            default:               state_d = ST_OT_MUL;
          endcase
        end
      end
      ST_BASS_OUT: if (out_free_i) begin
        op = sssf_pkg::OP_BASS_OUT; state_d = ST_IDLE;
      end
      ST_VOC_DIFF: begin op = sssf_pkg::OP_VOC_DIFF; state_d = ST_VOC_MUL; end
      ST_VOC_MUL:  begin op = sssf_pkg::OP_VOC_MUL;  state_d = ST_VOC_OUT; end
      ST_VOC_OUT: if (out_free_i) begin
        op = sssf_pkg::OP_VOC_OUT; state_d = ST_IDLE;
      end
      ST_DR_ABS:  begin op = sssf_pkg::OP_DR_ABS;  state_d = ST_DR_DIFF; end
      ST_DR_DIFF: begin op = sssf_pkg::OP_DR_DIFF; state_d = ST_DR_MUL;  end
      ST_DR_MUL:  begin op = sssf_pkg::OP_DR_MUL;  state_d = ST_DR_ENV;  end
      ST_DR_ENV:  begin op = sssf_pkg::OP_DR_ENV;  state_d = ST_DR_GAIN; end
      ST_DR_GAIN: begin op = sssf_pkg::OP_DR_GAIN; state_d = ST_DR_MG;   end
      ST_DR_MG:   begin op = sssf_pkg::OP_DR_MG;   state_d = ST_DR_RG;   end
      ST_DR_RG:   begin op = sssf_pkg::OP_DR_RG;   state_d = ST_DR_MH;   end
      ST_DR_MH:   begin op = sssf_pkg::OP_DR_MH;   state_d = ST_DR_ACC0; end
      ST_DR_ACC0: begin op = sssf_pkg::OP_DR_ACC0; state_d = ST_DR_ACC1; end
      ST_DR_ACC1: begin op = sssf_pkg::OP_DR_ACC1; state_d = ST_DR_OUT;  end
      ST_DR_OUT: if (out_free_i) begin
        op = sssf_pkg::OP_DR_OUT; state_d = ST_IDLE;
      end
      ST_OT_MUL: begin op = sssf_pkg::OP_OT_MUL; state_d = ST_OT_OUT; end
      ST_OT_OUT: if (out_free_i) begin
        op = sssf_pkg::OP_OT_OUT; state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign cmd_o = '{op: op, hi: hi_q, src_side: src_q, stage: stage_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      hi_q    <= 1'b0;
      src_q   <= 1'b0;
      stage_q <= '0;
    end else begin
      state_q <= state_d;
      hi_q    <= hi_d;
      src_q   <= src_d;
      stage_q <= stage_d;
    end
  end

endmodule

@@ rtl/core/sssf_datapath.sv @@
// ----------------------------------------------------------------------------
// Stem split filter datapath
// One shared multiplier, cascade state, envelope, smoother and result register.
// ----------------------------------------------------------------------------
module sssf_datapath #(
  parameter int BIQUAD_STAGES = sssf_pkg::DEF_STAGES
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  sssf_pkg::dp_cmd_t                        cmd_i,
  input  logic signed [sssf_pkg::SAMPLE_BITS-1:0]  left_in_i,
  input  logic signed [sssf_pkg::SAMPLE_BITS-1:0]  right_in_i,
  input  logic                                     block_start_i,
  input  logic signed [sssf_pkg::COEF_BITS-1:0]    low_b0_i,
  input  logic signed [sssf_pkg::COEF_BITS-1:0]    high_b0_i,
  input  logic signed [sssf_pkg::COEF_BITS-1:0]    den_a1_i,
  input  logic signed [sssf_pkg::COEF_BITS-1:0]    den_a2_i,
  input  logic                                     out_ready_i,
  output logic                                     out_valid_o,
  output logic                                     out_free_o,
  output logic signed [sssf_pkg::SAMPLE_BITS-1:0]  left_out_o,
  output logic signed [sssf_pkg::SAMPLE_BITS-1:0]  right_out_o
);

  localparam int SW    = sssf_pkg::SAMPLE_BITS;
  localparam int TW    = sssf_pkg::STATE_BITS;
  localparam int AW    = sssf_pkg::MUL_A_BITS;
  localparam int BW    = sssf_pkg::MUL_B_BITS;
  localparam int PW    = sssf_pkg::PROD_BITS;
  localparam int IDX_W = (BIQUAD_STAGES > 1) ? $clog2(BIQUAD_STAGES) : 1;
  localparam logic signed [63:0] Amax = (64'sd1 <<< sssf_pkg::SAMPLE_FRAC) - 64'sd1;
  localparam logic signed [63:0] Unity = 64'sd1 <<< sssf_pkg::SAMPLE_FRAC;
  localparam logic signed [63:0] GainCap = 64'sd3 <<< sssf_pkg::SAMPLE_FRAC;

  logic signed [TW-1:0] s1_lo_q [BIQUAD_STAGES];
  logic signed [TW-1:0] s2_lo_q [BIQUAD_STAGES];
  logic signed [TW-1:0] s1_hi_q [BIQUAD_STAGES];
  logic signed [TW-1:0] s2_hi_q [BIQUAD_STAGES];

  logic signed [SW-1:0] mid_q, side_q, p_q, left_q, right_q;
  logic        [SW-1:0] env_q;
  logic signed [TW-1:0] x_q, y_q, lo_res_q, hi_res_q;
  logic signed [AW-1:0] t_q, acc_q;
  logic signed [BW-1:0] g_q;
  logic signed [PW-1:0] prod_q, p0_q;
  logic                 att_q, valid_q;

  logic [IDX_W-1:0]     idx;
  logic signed [TW-1:0] s1_rd, s2_rd;
  logic signed [AW-1:0] mul_a;
  logic signed [BW-1:0] mul_b;
  logic                 mul_en;
  logic signed [63:0]   prod_w, p0_w, nb1, env_w;
  logic signed [63:0]   y_w, s1_w, s2_w, env_nx, s_w, p_nx;
  logic signed [SW:0]   sum_w, dif_w;
  logic                 out_op;

  assign idx   = cmd_i.stage[IDX_W-1:0];
  assign s1_rd = cmd_i.hi ? s1_hi_q[idx] : s1_lo_q[idx];
  assign s2_rd = cmd_i.hi ? s2_hi_q[idx] : s2_lo_q[idx];

  // shared multiplier operand select
  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b1;
    unique case (cmd_i.op)
      sssf_pkg::OP_BQ_B0: begin
        mul_a = AW'(x_q);
        mul_b = BW'(cmd_i.hi ? high_b0_i : low_b0_i);
      end
      sssf_pkg::OP_BQ_A1:   begin mul_a = AW'(y_q);      mul_b = BW'(den_a1_i); end
      sssf_pkg::OP_BQ_S1:   begin mul_a = AW'(y_q);      mul_b = BW'(den_a2_i); end
      sssf_pkg::OP_VOC_MUL: begin mul_a = t_q;           mul_b = sssf_pkg::K_SMOOTH; end
      sssf_pkg::OP_DR_MUL: begin
        mul_a = t_q;
        mul_b = att_q ? sssf_pkg::K_ATTACK : sssf_pkg::K_RELEASE;
      end
      sssf_pkg::OP_DR_MG:   begin mul_a = AW'(hi_res_q); mul_b = g_q; end
      sssf_pkg::OP_DR_MH:   begin mul_a = t_q;           mul_b = sssf_pkg::K_HIGH_GAIN; end
      sssf_pkg::OP_DR_ACC0: begin mul_a = AW'(lo_res_q); mul_b = sssf_pkg::K_LOW_GAIN; end
      sssf_pkg::OP_DR_ACC1: begin mul_a = AW'(side_q);   mul_b = sssf_pkg::K_SIDE_GAIN; end
      sssf_pkg::OP_OT_MUL:  begin mul_a = AW'(hi_res_q); mul_b = sssf_pkg::K_OTHER_GAIN; end
      default: mul_en = 1'b0;
    endcase
  end

  always_comb begin
    prod_w = 64'(prod_q);
    p0_w   = 64'(p0_q);
    nb1    = cmd_i.hi ? -(p0_w <<< 1) : (p0_w <<< 1);
    env_w  = $signed({{(64 - SW){1'b0}}, env_q});
    y_w    = sssf_pkg::sat(sssf_pkg::rnd(prod_w, sssf_pkg::COEF_FRAC) + 64'(s1_rd), TW);
    s1_w   = sssf_pkg::sat(sssf_pkg::rnd(nb1 - prod_w, sssf_pkg::COEF_FRAC) + 64'(s2_rd),
                           TW);
    s2_w   = sssf_pkg::sat(sssf_pkg::rnd(p0_w - prod_w, sssf_pkg::COEF_FRAC), TW);
    env_nx = env_w + sssf_pkg::rnd(prod_w, sssf_pkg::Q16_FRAC);
    if (env_nx < 64'sd0) env_nx = 64'sd0;
    if (env_nx > Amax)   env_nx = Amax;
    s_w    = sssf_pkg::rnd(prod_w, sssf_pkg::Q16_FRAC);
    p_nx   = sssf_pkg::sat(64'(p_q) + s_w, SW);
    sum_w  = (SW + 1)'(left_in_i) + (SW + 1)'(right_in_i);
    dif_w  = (SW + 1)'(left_in_i) - (SW + 1)'(right_in_i);
  end

  assign out_op = (cmd_i.op == sssf_pkg::OP_BASS_OUT) || (cmd_i.op == sssf_pkg::OP_VOC_OUT) ||
                  (cmd_i.op == sssf_pkg::OP_DR_OUT)   || (cmd_i.op == sssf_pkg::OP_OT_OUT);
  assign out_free_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign left_out_o  = left_q;
  assign right_out_o = right_q;

  // payload registers
  always_ff @(posedge clk_i) begin
    if (mul_en) begin
      prod_q <= PW'(mul_a) * PW'(mul_b);
    end
    unique case (cmd_i.op)
      sssf_pkg::OP_LOAD: begin
        mid_q  <= sum_w[SW:1];
        side_q <= dif_w[SW:1];
      end
      sssf_pkg::OP_CX_START: x_q <= cmd_i.src_side ? TW'(side_q) : TW'(mid_q);
      sssf_pkg::OP_BQ_Y: begin
        y_q  <= y_w[TW-1:0];
        p0_q <= prod_q;
      end
      sssf_pkg::OP_BQ_S2: x_q <= y_q;
      sssf_pkg::OP_CX_END: begin
        if (cmd_i.hi) hi_res_q <= x_q;
        else          lo_res_q <= x_q;
      end
      sssf_pkg::OP_BASS_OUT: begin
        left_q  <= SW'(sssf_pkg::sat(64'(lo_res_q), SW));
        right_q <= SW'(sssf_pkg::sat(64'(lo_res_q), SW));
      end
      sssf_pkg::OP_VOC_DIFF:
        t_q <= AW'(sssf_pkg::sat(64'(hi_res_q), SW) - 64'(p_q));
      sssf_pkg::OP_VOC_OUT: begin
        left_q  <= p_nx[SW-1:0];
        right_q <= p_nx[SW-1:0];
      end
      sssf_pkg::OP_DR_ABS: begin
        if (hi_res_q < 0) t_q <= -AW'(hi_res_q);
        else              t_q <= AW'(hi_res_q);
      end
      sssf_pkg::OP_DR_DIFF: begin
        att_q <= (64'(t_q < Amax[AW-1:0] ? t_q : Amax[AW-1:0])) > env_w;
        t_q   <= AW'(64'(t_q < Amax[AW-1:0] ? t_q : Amax[AW-1:0]) - env_w);
      end
      sssf_pkg::OP_DR_GAIN:
        g_q <= BW'((Unity + (env_w <<< 1)) > GainCap ? GainCap : (Unity + (env_w <<< 1)));
      sssf_pkg::OP_DR_RG: t_q <= AW'(sssf_pkg::rnd(prod_w, sssf_pkg::SAMPLE_FRAC));
      sssf_pkg::OP_DR_ACC0: acc_q <= AW'(s_w);
      sssf_pkg::OP_DR_ACC1: acc_q <= AW'(64'(acc_q) + s_w);
      sssf_pkg::OP_DR_OUT: begin
        left_q  <= SW'(sssf_pkg::sat(64'(acc_q) + s_w, SW));
        right_q <= SW'(sssf_pkg::sat(64'(acc_q) - s_w, SW));
      end
      sssf_pkg::OP_OT_OUT: begin
        left_q  <= SW'(sssf_pkg::sat(s_w, SW));
        right_q <= SW'(sssf_pkg::sat(-s_w, SW));
      end
      default: ;
    endcase
  end

  // filter state, envelope, smoother and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < BIQUAD_STAGES; i++) begin
        s1_lo_q[i] <= '0;
        s2_lo_q[i] <= '0;
        s1_hi_q[i] <= '0;
        s2_hi_q[i] <= '0;
      end
      p_q     <= '0;
      env_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (out_op)           valid_q <= 1'b1;
      else if (out_ready_i) valid_q <= 1'b0;
      unique case (cmd_i.op)
        sssf_pkg::OP_LOAD: if (block_start_i) begin
          p_q   <= '0;
          env_q <= '0;
        end
        sssf_pkg::OP_BQ_S1: begin
          if (cmd_i.hi) s1_hi_q[idx] <= s1_w[TW-1:0];
          else          s1_lo_q[idx] <= s1_w[TW-1:0];
        end
        sssf_pkg::OP_BQ_S2: begin
          if (cmd_i.hi) s2_hi_q[idx] <= s2_w[TW-1:0];
          else          s2_lo_q[idx] <= s2_w[TW-1:0];
        end
        sssf_pkg::OP_VOC_OUT: p_q   <= p_nx[SW-1:0];
        sssf_pkg::OP_DR_ENV:  env_q <= env_nx[SW-1:0];
        default: ;
      endcase
    end
  end

  a_out_only_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_op |-> out_free_o) else $error("result written over a pending transfer");

  a_out_valid_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_op |=> valid_q) else $error("result not presented after write");

  a_env_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    64'(env_q) <= Amax) else $error("envelope out of range");

  a_stage_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == sssf_pkg::OP_BQ_S1 || cmd_i.op == sssf_pkg::OP_BQ_S2)
      |-> (int'(cmd_i.stage) < BIQUAD_STAGES)) else $error("stage index out of range");

endmodule

@@ rtl/core/stereo_stem_split_filter_core.sv @@
// ----------------------------------------------------------------------------
// Stereo stem split filter core
// Mid/side split, lowpass and highpass biquad cascades, stem selection.
// ----------------------------------------------------------------------------
// One stereo pair enters per input transfer and one saturated stereo pair
// leaves per output transfer. Items are processed one at a time through a
// single shared 36x27 multiplier; each biquad stage runs its B0, Y, A1, S1
// and S2 steps on it. Drums mode runs both the lowpass and the highpass
// cascade; the other modes run one. The result register is written as the
// core returns to idle, and it lets the next input be taken while the last
// result still waits; the core only stalls if a new result is ready before
// the previous one was taken. Configuration is written over APB; the user
// must write it only while idle, as the core itself does not enforce this.
// ----------------------------------------------------------------------------
module stereo_stem_split_filter_core #(
  parameter int BIQUAD_STAGES = sssf_pkg::DEF_STAGES
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // [23:0] left_in, [47:24] right_in
  input  logic        s_axis_tuser,   // block_start
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [23:0] left_out, [47:24] right_out
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int SW = sssf_pkg::SAMPLE_BITS;
  localparam int CW = sssf_pkg::COEF_BITS;

  logic [1:0]           stem_mode_q;
  logic signed [CW-1:0] low_b0_q, high_b0_q, den_a1_q, den_a2_q;
  logic                 cfg_wr;
  logic [2:0]           reg_idx;

  sssf_pkg::dp_cmd_t    cmd;
  logic                 out_free;
  logic signed [SW-1:0] left_out, right_out;

  // APB: zero wait states; write lands on the access cycle
  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stem_mode_q <= sssf_pkg::MODE_BASS;
      low_b0_q    <= '0;
      high_b0_q   <= '0;
      den_a1_q    <= '0;
      den_a2_q    <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        sssf_pkg::REG_STEM_MODE: stem_mode_q <= pwdata[1:0];
        sssf_pkg::REG_LOW_B0:    low_b0_q    <= pwdata[CW-1:0];
        sssf_pkg::REG_HIGH_B0:   high_b0_q   <= pwdata[CW-1:0];
        sssf_pkg::REG_DEN_A1:    den_a1_q    <= pwdata[CW-1:0];
        sssf_pkg::REG_DEN_A2:    den_a2_q    <= pwdata[CW-1:0];
        default: ;  // unmapped: write dropped
      endcase
    end
  end

  // read back, coefficients sign-extended
  always_comb begin
    unique case (reg_idx)
      sssf_pkg::REG_STEM_MODE: prdata = {30'd0, stem_mode_q};
      sssf_pkg::REG_LOW_B0:    prdata = 32'(low_b0_q);
      sssf_pkg::REG_HIGH_B0:   prdata = 32'(high_b0_q);
      sssf_pkg::REG_DEN_A1:    prdata = 32'(den_a1_q);
      sssf_pkg::REG_DEN_A2:    prdata = 32'(den_a2_q);
      default:                 prdata = '0;
    endcase
  end

  sssf_ctrl #(
    .BIQUAD_STAGES (BIQUAD_STAGES)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .stem_mode_i (stem_mode_q),
    .in_valid_i  (s_axis_tvalid),
    .out_free_i  (out_free),
    .in_ready_o  (s_axis_tready),
    .cmd_o       (cmd)
  );

  sssf_datapath #(
    .BIQUAD_STAGES (BIQUAD_STAGES)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .left_in_i     (s_axis_tdata[SW-1:0]),
    .right_in_i    (s_axis_tdata[2*SW-1:SW]),
    .block_start_i (s_axis_tuser),
    .low_b0_i      (low_b0_q),
    .high_b0_i     (high_b0_q),
    .den_a1_i      (den_a1_q),
    .den_a2_i      (den_a2_q),
    .out_ready_i   (m_axis_tready),
    .out_valid_o   (m_axis_tvalid),
    .out_free_o    (out_free),
    .left_out_o    (left_out),
    .right_out_o   (right_out)
  );

  assign m_axis_tdata = {right_out, left_out};

endmodule

@@ sim/tb_top.sv @@
// ----------------------------------------------------------------------------
// Stereo stem split filter core testbench
// Streams stereo pairs through every stem mode under random idling and a long
// output stall, and checks each output transfer against a bit-exact predictor.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSTG    = sssf_pkg::DEF_STAGES;
  localparam int NREGS   = sssf_pkg::NUM_REGS;
  localparam int DRAIN   = 100;  // comfortably above the drums item time
  localparam int HOLDOFF = 400;  // long output stall

  // register indexes
  localparam int REG_MODE   = int'(sssf_pkg::REG_STEM_MODE);
  localparam int REG_LOW_B0 = int'(sssf_pkg::REG_LOW_B0);
  localparam int REG_HI_B0  = int'(sssf_pkg::REG_HIGH_B0);
  localparam int REG_A1     = int'(sssf_pkg::REG_DEN_A1);
  localparam int REG_A2     = int'(sssf_pkg::REG_DEN_A2);

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;   // [23:0] left_in, [47:24] right_in
  logic        s_axis_tuser = 1'b0; // block_start
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;        // [23:0] left_out, [47:24] right_out
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  stereo_stem_split_filter_core dut (.*);

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // idling percentages and the long-stall request
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  bit          stall_req   = 1'b0;
  int          err_cnt     = 0;

  // expected output pairs, oldest first
  logic [47:0] stem_q[$];

  // ---------------- predictor state ----------------
  logic [1:0] p_mode;
  longint     p_low_b0, p_hi_b0, p_a1, p_a2;
  longint     lo_st[2*NSTG];
  longint     hi_st[2*NSTG];
  longint     smooth_prev;
  longint     drum_env;

  // floor((v + 2^(n-1)) / 2^n)
  function automatic longint rshr(longint v, int n);
    return (v + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

  function automatic longint clip(longint v, int bits);
    longint hi;
    hi = (64'sd1 <<< (bits - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  function automatic longint sext26(logic [31:0] v);
    return longint'($signed(v[sssf_pkg::COEF_BITS-1:0]));
  endfunction

  // one biquad cascade, advancing its state; highpass uses b1 = -2*b0
  function automatic longint cascade(bit hp, longint xin);
    longint x, y, s1, s2, b0, b1;
    x  = xin;
    b0 = hp ? p_hi_b0 : p_low_b0;
    b1 = hp ? -2 * b0 : 2 * b0;
    for (int k = 0; k < NSTG; k++) begin
      s1 = hp ? hi_st[2*k] : lo_st[2*k];
      s2 = hp ? hi_st[2*k+1] : lo_st[2*k+1];
      y  = clip(rshr(b0 * x, sssf_pkg::COEF_FRAC) + s1, sssf_pkg::STATE_BITS);
      s1 = clip(rshr(b1 * x - p_a1 * y, sssf_pkg::COEF_FRAC) + s2, sssf_pkg::STATE_BITS);
      s2 = clip(rshr(b0 * x - p_a2 * y, sssf_pkg::COEF_FRAC), sssf_pkg::STATE_BITS);
      if (hp) begin
        hi_st[2*k] = s1; hi_st[2*k+1] = s2;
      end else begin
        lo_st[2*k] = s1; lo_st[2*k+1] = s2;
      end
      x = y;
    end
    return x;
  endfunction

  // expected output pair for one accepted stereo pair
  function automatic logic [47:0] stem_predict(logic [23:0] l_in, logic [23:0] r_in,
                                               logic bstart);
    longint l, r, mid, side, lo, ro, h, lowv, mh, a, amax, g, d, s;
    l    = longint'($signed(l_in));
    r    = longint'($signed(r_in));
    mid  = (l + r) >>> 1;
    side = (l - r) >>> 1;
    amax = (64'sd1 <<< sssf_pkg::SAMPLE_FRAC) - 1;
    if (bstart) begin
      smooth_prev = 0;
      drum_env    = 0;
    end
    case (p_mode)
      sssf_pkg::MODE_BASS: begin
        lo = clip(cascade(1'b0, mid), sssf_pkg::SAMPLE_BITS);
        ro = lo;
      end
      sssf_pkg::MODE_VOCALS: begin
        h = clip(cascade(1'b1, mid), sssf_pkg::SAMPLE_BITS);
        smooth_prev = clip(smooth_prev + rshr(19661 * (h - smooth_prev), 16),
                           sssf_pkg::SAMPLE_BITS);
        lo = smooth_prev;
        ro = smooth_prev;
      end
      sssf_pkg::MODE_DRUMS: begin
        lowv = cascade(1'b0, mid);
        mh   = cascade(1'b1, mid);
        a    = (mh < 0) ? -mh : mh;
        if (a > amax) a = amax;
        if (a > drum_env) drum_env += rshr(6554 * (a - drum_env), 16);
        else              drum_env += rshr(66 * (a - drum_env), 16);
        if (drum_env < 0) drum_env = 0;
        if (drum_env > amax) drum_env = amax;
        g = (64'sd1 <<< sssf_pkg::SAMPLE_FRAC) + 2 * drum_env;
        if (g > (64'sd3 <<< sssf_pkg::SAMPLE_FRAC)) g = 64'sd3 <<< sssf_pkg::SAMPLE_FRAC;
        d  = rshr(78643 * lowv, 16) +
             rshr(52429 * rshr(mh * g, sssf_pkg::SAMPLE_FRAC), 16);
        s  = rshr(19661 * side, 16);
        lo = clip(d + s, sssf_pkg::SAMPLE_BITS);
        ro = clip(d - s, sssf_pkg::SAMPLE_BITS);
      end
      default: begin
        s  = rshr(98304 * cascade(1'b1, side), 16);
        lo = clip(s, sssf_pkg::SAMPLE_BITS);
        ro = clip(-s, sssf_pkg::SAMPLE_BITS);
      end
    endcase
    return {ro[23:0], lo[23:0]};
  endfunction

  // ---------------- stimulus helpers ----------------
  // APB write: setup cycle, then access cycle; the register updates at the end
  // of the access cycle, then the bus idles so the next transfer starts on a fresh edge
  task automatic cfg_write(int idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 5'(4 * idx);
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_MODE:   p_mode   = val[1:0];
      REG_LOW_B0: p_low_b0 = sext26(val);
      REG_HI_B0:  p_hi_b0  = sext26(val);
      REG_A1:     p_a1     = sext26(val);
      REG_A2:     p_a2     = sext26(val);
      default: ;  // unmapped address, ignored
    endcase
    @(posedge clk_i);
  endtask

  // offer one stereo pair, maybe after random idle cycles; valid stays high
  // afterwards until the next call decides
  task automatic send_pair(logic [23:0] l, logic [23:0] r, logic bstart);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {r, l};
    s_axis_tuser  <= bstart;
    do @(posedge clk_i); while (!s_axis_tready);
    stem_q.push_back(stem_predict(l, r, bstart));
  endtask

  // stop offering, wait for every expected pair, then let the core settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (stem_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  task automatic set_filters(logic [31:0] lb, logic [31:0] hb, logic [31:0] a1,
                             logic [31:0] a2);
    cfg_write(REG_LOW_B0, lb);
    cfg_write(REG_HI_B0, hb);
    cfg_write(REG_A1, a1);
    cfg_write(REG_A2, a2);
  endtask

  // random sample: mostly moderate, sometimes full range or an extreme
  function automatic logic [23:0] rand_sample();
    case ($urandom_range(9))
      0:       return 24'h7FFFFF;
      1:       return 24'h800000;
      2, 3:    return 24'($urandom);
      default: return 24'($signed(20'($urandom)));
    endcase
  endfunction

  // a stable-ish shared denominator with jitter, or fully random coefficients
  task automatic random_filters();
    if ($urandom_range(4) == 0) begin
      set_filters($urandom, $urandom, $urandom, $urandom);
    end else begin
      set_filters(32'(104858 + $urandom_range(40000) - 20000),
                  32'(6795000 + $urandom_range(400000) - 200000),
                  32'(-13421773 + int'($urandom_range(600000)) - 300000),
                  32'(5452595 + int'($urandom_range(400000)) - 200000));
    end
  endtask

  // ---------------- tests ----------------
  // every mode with extreme samples, coefficient extremes and unmapped writes
  task automatic test_directed();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    // reset coefficients are zero: every mode yields zero or only side terms
    for (int m = 0; m < 4; m++) begin
      cfg_write(REG_MODE, 32'(m));
      send_pair(24'h7FFFFF, 24'h800000, 1'b1);
      drain();
    end
    // unmapped addresses must not disturb anything
    cfg_write(NREGS, 32'hFFFF_FFFF);
    cfg_write(NREGS + 2, 32'h1234_5678);
    set_filters(32'd104858, 32'd6795000, -32'sd13421773, 32'd5452595);
    for (int m = 0; m < 4; m++) begin
      cfg_write(REG_MODE, 32'hFFFF_FFFC | 32'(m));
      send_pair(24'h7FFFFF, 24'h7FFFFF, 1'b1);
      send_pair(24'h800000, 24'h800000, 1'b0);
      send_pair(24'h7FFFFF, 24'h800000, 1'b0);
      drain();
    end
    // unstable extremes: cascade state pins at the 32-bit rails
    set_filters(32'h01FF_FFFF, 32'h0200_0000, 32'h0200_0000, 32'h01FF_FFFF);
    for (int m = 0; m < 4; m++) begin
      cfg_write(REG_MODE, 32'(m));
      send_pair(24'h7FFFFF, 24'h000000, 1'b0);
      send_pair(24'h800000, 24'h7FFFFF, 1'b1);
      drain();
    end
  endtask

  // long output stall while the sender keeps offering, in drums mode
  task automatic test_backpressure();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    set_filters(32'd104858, 32'd6795000, -32'sd13421773, 32'd5452595);
    cfg_write(REG_MODE, 32'(sssf_pkg::MODE_DRUMS));
    stall_req = 1'b1;
    for (int i = 0; i < 30; i++) send_pair(rand_sample(), rand_sample(), i == 0);
    drain();
  endtask

  // random phases: random mode and filters, block starts now and then
  task automatic test_random(int phases, int per_phase);
    for (int ph = 0; ph < phases; ph++) begin
      // idling schedule: sender light / receiver heavy, swapped, then none
      if (ph < phases / 3) begin
        tx_idle_pct = 30; rx_idle_pct = 67;
      end else if (ph < 2 * phases / 3) begin
        tx_idle_pct = 67; rx_idle_pct = 30;
      end else begin
        tx_idle_pct = 0;  rx_idle_pct = 0;
      end
      cfg_write(REG_MODE, $urandom);
      random_filters();
      for (int i = 0; i < per_phase; i++)
        send_pair(rand_sample(), rand_sample(), (i == 0) || ($urandom_range(31) == 0));
      drain();
    end
  endtask

  // ---------------- output side ----------------
  // receiver: random idling, plus a counted long stall on request
  initial begin
    int unsigned hold;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (stall_req && hold == 0) begin
        hold      = HOLDOFF;
        stall_req = 1'b0;
      end
      if (hold != 0) begin
        hold--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // checker: each output transfer against the oldest expectation
  always @(posedge clk_i) begin
    logic [47:0] exp_pair;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (stem_q.size() == 0) begin
        $error("unexpected output transfer %h", m_axis_tdata);
        err_cnt++;
      end else begin
        exp_pair = stem_q.pop_front();
        if (m_axis_tdata[23:0] !== exp_pair[23:0]) begin
          $error("left_out: expected %h, got %h", exp_pair[23:0], m_axis_tdata[23:0]);
          err_cnt++;
        end
        if (m_axis_tdata[47:24] !== exp_pair[47:24]) begin
          $error("right_out: expected %h, got %h", exp_pair[47:24], m_axis_tdata[47:24]);
          err_cnt++;
        end
      end
    end
  end

  // ---------------- sequence ----------------
  initial begin
    p_mode      = sssf_pkg::MODE_BASS;
    p_low_b0    = 0;
    p_hi_b0     = 0;
    p_a1        = 0;
    p_a2        = 0;
    smooth_prev = 0;
    drum_env    = 0;
    foreach (lo_st[i]) lo_st[i] = 0;
    foreach (hi_st[i]) hi_st[i] = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_backpressure();
    test_random(12, 150);

    if (err_cnt == 0 && stem_q.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  // run limit
  initial begin
    #20ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/sssf_pkg.sv
rtl/core/sssf_ctrl.sv
rtl/core/sssf_datapath.sv
rtl/core/stereo_stem_split_filter_core.sv
sim/tb_top.sv
